[rtl/core/msrg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrg_pkg: shared types and control store of the servo ramp generator
// Holds the opcode codes, the control word layout, the microprogram ROM and
// the dispatch table used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package msrg_pkg;

  localparam int CHANNELS_DEF = 21;
  localparam logic signed [13:0] REST_PULSE = 14'sd1500;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  // quotient / dividend magnitude width of the step divider
  localparam int DIV_W = 15;
  localparam int DVS_W = 8;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_CAL  = 2'd2,
    OP_MAP  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_FETCH,
    ACT_LOOKUP,
    ACT_DIV_START,
    ACT_SET_WRITE,
    ACT_CAL_WRITE,
    ACT_MAP_WRITE,
    ACT_MOVE,
    ACT_MARKER
  } act_t;

  // goto: target; if: cond ? target : next; hold: cond ? stay : target;
  // dispatch: accepted transaction ? opcode entry : stay
  typedef enum logic [1:0] {
    BR_GOTO,
    BR_IF,
    BR_HOLD,
    BR_DISPATCH
  } br_t;

  typedef enum logic [2:0] {
    COND_SET_BAD,
    COND_PHYS_BAD,
    COND_DIV_BUSY,
    COND_MOVE_STAY,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [3:0] uaddr_t;

  localparam uaddr_t UA_FETCH  = 4'd0;
  localparam uaddr_t UA_LOOKUP = 4'd1;
  localparam uaddr_t UA_DIV    = 4'd2;
  localparam uaddr_t UA_WAIT   = 4'd3;
  localparam uaddr_t UA_SETWR  = 4'd4;
  localparam uaddr_t UA_CAL    = 4'd5;
  localparam uaddr_t UA_MAP    = 4'd6;
  localparam uaddr_t UA_MOVE   = 4'd7;
  localparam uaddr_t UA_MARK   = 4'd8;

  typedef struct packed {
    act_t   act;
    br_t    br;
    cond_t  cond;
    uaddr_t target;
  } ctrl_t;

  typedef struct packed {
    logic    in_accept;
    opcode_t opcode;
    logic    set_bad;
    logic    phys_bad;
    logic    div_busy;
    logic    out_busy;
    logic    last_ch;
  } stat_t;

  function automatic ctrl_t ucode_rom(input uaddr_t a);
    ctrl_t w;
    unique case (a)
      UA_FETCH:  w = '{ACT_FETCH,     BR_DISPATCH, COND_OUT_BUSY,  UA_FETCH};
      UA_LOOKUP: w = '{ACT_LOOKUP,    BR_IF,       COND_SET_BAD,   UA_FETCH};
      UA_DIV:    w = '{ACT_DIV_START, BR_IF,       COND_PHYS_BAD,  UA_FETCH};
      UA_WAIT:   w = '{ACT_NOP,       BR_HOLD,     COND_DIV_BUSY,  UA_SETWR};
      UA_SETWR:  w = '{ACT_SET_WRITE, BR_GOTO,     COND_OUT_BUSY,  UA_FETCH};
      UA_CAL:    w = '{ACT_CAL_WRITE, BR_GOTO,     COND_OUT_BUSY,  UA_FETCH};
      UA_MAP:    w = '{ACT_MAP_WRITE, BR_GOTO,     COND_OUT_BUSY,  UA_FETCH};
      UA_MOVE:   w = '{ACT_MOVE,      BR_HOLD,     COND_MOVE_STAY, UA_MARK};
      UA_MARK:   w = '{ACT_MARKER,    BR_HOLD,     COND_OUT_BUSY,  UA_FETCH};
      default:   w = '{ACT_NOP,       BR_GOTO,     COND_OUT_BUSY,  UA_FETCH};
    endcase
    return w;
  endfunction

  function automatic uaddr_t dispatch(input opcode_t op);
    uaddr_t a;
    unique case (op)
      OP_SET:  a = UA_LOOKUP;
      OP_TICK: a = UA_MOVE;
      OP_CAL:  a = UA_CAL;
      OP_MAP:  a = UA_MAP;
      default: a = UA_FETCH;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/core/multi_servo_ramp_generator.sv]
// tick: accepted, then every channel is visited in turn, one channel per cycle
//   while the output is not held, then the end marker is sent once the output
//   is free; only a channel with a nonzero step sends an update
// set target: lookup, start and wait on the one-bit-per-cycle divider, step write
// calibration or order map write: fetch, then the table write step
// reset (synchronous, active low) restores all tables directly, no clear pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_ramp_generator: multi-channel servo ramp generator
// Microcoded sequencer over a channel-table datapath that ramps servo pulse
// widths toward their targets one step per tick.
// ----------------------------------------------------------------------------
module multi_servo_ramp_generator #(
  parameter int CHANNELS = msrg_pkg::CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // channel[4:0], target_pulse[16:5], divisor[24:17], offset[34:25],
  // map_entry[39:35]
  input  wire logic [msrg_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  wire logic [msrg_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_channel[4:0], pulse[17:5], zero fill[23:18]
  output logic [msrg_pkg::OUT_DATA_W-1:0]      out_tdata,
  // is_update
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  msrg_pkg::ctrl_t ctrl;
  msrg_pkg::stat_t stat;

  msrg_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  msrg_dpath #(
    .CHANNELS(CHANNELS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[rtl/core/msrg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrg_div: serial restoring divider
// Unsigned divide of a step magnitude by the tick count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module msrg_div #(
  parameter int DW = msrg_pkg::DIV_W,
  parameter int VW = msrg_pkg::DVS_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic [DW-1:0]      quot
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;

  logic [VW:0]   trial;
  logic [VW:0]   trial_sub;
  logic          ge;

  assign trial     = {rem_r, q_r[DW-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dvs_r != '0)
    else $error("divider running with zero divisor");

endmodule
`default_nettype wire

[rtl/core/msrg_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrg_dpath: channel tables and arithmetic of the servo ramp generator
// Executes one control word per cycle: command capture, target and step
// setup, per-channel ramp move and the output register.
// ----------------------------------------------------------------------------
module msrg_dpath #(
  parameter int CHANNELS = msrg_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire msrg_pkg::ctrl_t                     ctrl,
  output msrg_pkg::stat_t                          stat,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [msrg_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [msrg_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [msrg_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0] CH_LIM = 6'(CHANNELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // channel tables
  logic signed [13:0] tgt_tbl_r  [CHANNELS];
  logic signed [13:0] cur_tbl_r  [CHANNELS];
  logic signed [14:0] step_tbl_r [CHANNELS];
  logic signed [9:0]  cal_tbl_r  [CHANNELS];
  logic [4:0]         map_tbl_r  [CHANNELS];

  // captured command
  logic [4:0]         chan_r;
  logic [11:0]        pulse_r;
  logic [7:0]         div_r;
  logic signed [9:0]  offs_r;
  logic [4:0]         map_val_r;

  logic [IDX_W-1:0]   ptr_r;
  logic [4:0]         phys_r;
  logic signed [13:0] tval_r;
  logic               neg_r;

  logic               out_valid_r;
  logic [4:0]         out_ch_r;
  logic signed [12:0] out_pulse_r;
  logic               out_upd_r;
  logic               out_last_r;

  logic               accept;
  logic               chan_ok;
  logic [IDX_W-1:0]   chan_idx;
  logic [IDX_W-1:0]   phys_idx;
  logic               out_busy;

  logic signed [13:0] t_calc;
  logic signed [14:0] diff;
  logic [14:0]        diff_mag;
  logic [7:0]         dvs;
  logic               div_start;
  logic               div_busy;
  logic [14:0]        quot;
  logic signed [14:0] step_new;

  logic signed [14:0] mv_s;
  logic signed [15:0] mv_cur;
  logic signed [15:0] mv_lim;
  logic signed [15:0] mv_sum;
  logic               mv_go;
  logic signed [13:0] mv_new_cur;
  logic signed [14:0] mv_new_step;
  logic signed [12:0] mv_rep;
  logic               do_move;
  logic               do_mark;

  assign in_tready = ctrl.act == msrg_pkg::ACT_FETCH;
  assign accept    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  assign chan_ok  = {1'b0, chan_r} < CH_LIM;
  assign chan_idx = chan_r[IDX_W-1:0];
  assign phys_idx = phys_r[IDX_W-1:0];

  // set target path
  assign t_calc   = $signed({2'b00, pulse_r}) - 14'(cal_tbl_r[chan_idx]);
  assign diff     = 15'(tval_r) - 15'(cur_tbl_r[phys_idx]);
  assign diff_mag = diff[14] ? 15'(-diff) : diff;
  assign dvs      = (div_r == 8'd0) ? 8'd1 : div_r;
  assign div_start = ctrl.act == msrg_pkg::ACT_DIV_START;
  assign step_new = neg_r ? 15'(16'sd0 - $signed({1'b0, quot})) : $signed(quot);

  msrg_div #(
    .DW(msrg_pkg::DIV_W),
    .VW(msrg_pkg::DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (quot)
  );

  // ramp move of the channel under the pointer
  assign mv_s   = step_tbl_r[ptr_r];
  assign mv_cur = 16'(cur_tbl_r[ptr_r]);
  assign mv_lim = 16'(tgt_tbl_r[ptr_r]) - 16'(mv_s);
  assign mv_sum = mv_cur + 16'(mv_s);
  assign mv_go  = mv_s[14] ? (mv_cur > mv_lim) : (mv_cur < mv_lim);
  assign mv_new_cur  = mv_go ? mv_sum[13:0] : tgt_tbl_r[ptr_r];
  assign mv_new_step = mv_go ? mv_s : 15'sd0;

  always_comb begin
    if (mv_new_cur > 14'sd4095) begin
      mv_rep = 13'sd4095;
    end else if (mv_new_cur < -14'sd4096) begin
      mv_rep = -13'sd4096;
    end else begin
      mv_rep = mv_new_cur[12:0];
    end
  end

  assign do_move = (ctrl.act == msrg_pkg::ACT_MOVE) && !out_busy;
  assign do_mark = (ctrl.act == msrg_pkg::ACT_MARKER) && !out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tgt_tbl_r[i]  <= msrg_pkg::REST_PULSE;
        cur_tbl_r[i]  <= msrg_pkg::REST_PULSE;
        step_tbl_r[i] <= '0;
        cal_tbl_r[i]  <= '0;
        map_tbl_r[i]  <= 5'(i);
      end
    end else begin
      unique case (ctrl.act)
        msrg_pkg::ACT_SET_WRITE: begin
          tgt_tbl_r[phys_idx]  <= tval_r;
          step_tbl_r[phys_idx] <= step_new;
        end
        msrg_pkg::ACT_CAL_WRITE: begin
          if (chan_ok) begin
            cal_tbl_r[chan_idx] <= offs_r;
          end
        end
        msrg_pkg::ACT_MAP_WRITE: begin
          if (chan_ok) begin
            map_tbl_r[chan_idx] <= map_val_r;
          end
        end
        msrg_pkg::ACT_MOVE: begin
          if (do_move && mv_s != '0) begin
            cur_tbl_r[ptr_r]  <= mv_new_cur;
            step_tbl_r[ptr_r] <= mv_new_step;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command capture and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r    <= in_tdata[4:0];
      pulse_r   <= in_tdata[16:5];
      div_r     <= in_tdata[24:17];
      offs_r    <= $signed(in_tdata[34:25]);
      map_val_r <= in_tdata[39:35];
    end
    if (ctrl.act == msrg_pkg::ACT_LOOKUP) begin
      phys_r <= map_tbl_r[chan_idx];
      tval_r <= t_calc;
    end
    if (div_start) begin
      neg_r <= diff[14];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (accept) begin
      ptr_r <= '0;
    end else if (do_move) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((do_move && mv_s != '0) || do_mark) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_move && mv_s != '0) begin
      out_ch_r    <= 5'(ptr_r);
      out_pulse_r <= mv_rep;
      out_upd_r   <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (do_mark) begin
      out_ch_r    <= '0;
      out_pulse_r <= '0;
      out_upd_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_pulse_r, out_ch_r};
  assign out_tuser  = out_upd_r;
  assign out_tlast  = out_last_r;

  assign stat.in_accept = accept;
  assign stat.opcode    = msrg_pkg::opcode_t'(in_tuser);
  assign stat.set_bad   = !chan_ok || (pulse_r == 12'd0);
  assign stat.phys_bad  = {1'b0, phys_r} >= CH_LIM;
  assign stat.div_busy  = div_busy;
  assign stat.out_busy  = out_busy;
  assign stat.last_ch   = ptr_r == LAST_IDX;

endmodule
`default_nettype wire

[rtl/core/msrg_useq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msrg_useq: microprogram sequencer
// Step counter over the control ROM with conditional holds, skips and the
// opcode dispatch on each accepted transaction.
// ----------------------------------------------------------------------------
module msrg_useq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire msrg_pkg::stat_t stat,
  output msrg_pkg::ctrl_t      ctrl
);

  msrg_pkg::uaddr_t uaddr_r;
  msrg_pkg::uaddr_t uaddr_nxt;
  msrg_pkg::uaddr_t uaddr_inc;
  logic             cond_hit;

  assign ctrl      = msrg_pkg::ucode_rom(uaddr_r);
  assign uaddr_inc = uaddr_r + 1'b1;

  always_comb begin
    unique case (ctrl.cond)
      msrg_pkg::COND_SET_BAD:   cond_hit = stat.set_bad;
      msrg_pkg::COND_PHYS_BAD:  cond_hit = stat.phys_bad;
      msrg_pkg::COND_DIV_BUSY:  cond_hit = stat.div_busy;
      msrg_pkg::COND_MOVE_STAY: cond_hit = stat.out_busy || !stat.last_ch;
      msrg_pkg::COND_OUT_BUSY:  cond_hit = stat.out_busy;
      default:                  cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.br)
      msrg_pkg::BR_GOTO:     uaddr_nxt = ctrl.target;
      msrg_pkg::BR_IF:       uaddr_nxt = cond_hit ? ctrl.target : uaddr_inc;
      msrg_pkg::BR_HOLD:     uaddr_nxt = cond_hit ? uaddr_r : ctrl.target;
      msrg_pkg::BR_DISPATCH: begin
        uaddr_nxt = stat.in_accept ? msrg_pkg::dispatch(stat.opcode) : uaddr_r;
      end
      default:               uaddr_nxt = msrg_pkg::UA_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uaddr_r <= msrg_pkg::UA_FETCH;
    end else begin
      uaddr_r <= uaddr_nxt;
    end
  end

  a_uaddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    uaddr_r <= msrg_pkg::UA_MARK)
    else $error("step counter left the program");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    stat.in_accept |=> uaddr_r != msrg_pkg::UA_FETCH)
    else $error("accepted transaction was not dispatched");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (uaddr_r == msrg_pkg::UA_WAIT && !stat.div_busy) |=> uaddr_r == msrg_pkg::UA_SETWR)
    else $error("divider finished but step was not written");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the multi-channel servo ramp generator
// Streams set-target, tick, calibration and order-map commands into the block,
// predicts every pulse update and end-of-tick marker from a ramp model kept
// in the bench, and checks each output transaction field by field. Both ends
// idle at random, and the output side is also held off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import msrg_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int RUN_ITEMS = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    opcode_t                op;
    logic [IN_DATA_W-1:0]   data;
    bit                     drain_first;
  } servo_cmd_t;

  typedef struct {
    logic [4:0]         ch;
    logic signed [12:0] pulse;
    logic               is_update;
    logic               last;
  } servo_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  multi_servo_ramp_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ramp model state
  int          tgt_pw[NCH];
  int          cur_pw[NCH];
  int          step_pw[NCH];
  int          trim_pw[NCH];
  int unsigned chan_map[NCH];

  servo_cmd_t    cmd_q[$];
  servo_result_t servo_results_q[$];
  servo_cmd_t    cur_cmd;

  bit offering = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_in_acc = 0;
  int n_fail = 0;
  int n_cycles = 0;

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic queue_cmd(opcode_t op, int ch, int pw, int dv, int ofs, int mp, bit drain);
    servo_cmd_t c;
    c.op = op;
    c.data = {mp[4:0], ofs[9:0], dv[7:0], pw[11:0], ch[4:0]};
    c.drain_first = drain;
    cmd_q.push_back(c);
  endtask

  task automatic predict_ramp_results(servo_cmd_t c);
    int ch, pw, dv, ofs, mp, phys, t, s, cur, tgt;
    servo_result_t r;
    ch = int'(c.data[4:0]);
    pw = int'(c.data[16:5]);
    dv = int'(c.data[24:17]);
    ofs = int'($signed(c.data[34:25]));
    mp = int'(c.data[39:35]);
    case (c.op)
      OP_SET: begin
        if (ch < NCH && pw > 0) begin
          phys = int'(chan_map[ch]);
          if (phys < NCH) begin
            t = clamp_int(pw - trim_pw[ch], -8192, 8191);
            if (dv == 0) dv = 1;
            tgt_pw[phys] = t;
            // int division truncates toward zero
            step_pw[phys] = clamp_int((t - cur_pw[phys]) / dv, -16384, 16383);
          end
        end
      end
      OP_CAL: begin
        if (ch < NCH) trim_pw[ch] = ofs;
      end
      OP_MAP: begin
        if (ch < NCH) chan_map[ch] = mp;
      end
      default: begin
        for (int i = 0; i < NCH; i++) begin
          s = step_pw[i];
          cur = cur_pw[i];
          tgt = tgt_pw[i];
          if (s != 0) begin
            if ((s > 0 && cur < tgt - s) || (s < 0 && cur > tgt - s)) begin
              cur = cur + s;
            end else begin
              cur = tgt;
              s = 0;
            end
            cur_pw[i] = clamp_int(cur, -8192, 8191);
            step_pw[i] = s;
            r.ch = i[4:0];
            r.pulse = 13'(clamp_int(cur_pw[i], -4096, 4095));
            r.is_update = 1'b1;
            r.last = 1'b0;
            servo_results_q.push_back(r);
          end
        end
        r.ch = '0;
        r.pulse = '0;
        r.is_update = 1'b0;
        r.last = 1'b1;
        servo_results_q.push_back(r);
      end
    endcase
  endtask

  // monitor: input accepts feed the model, output accepts are checked
  always @(posedge clk) begin
    servo_result_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_ramp_results(cur_cmd);
        in_taken = 1'b1;
        n_in_acc <= n_in_acc + 1;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        if (servo_results_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual ch %0d pulse %0d upd %0b last %0b",
                   $time, out_tdata[4:0], $signed(out_tdata[17:5]), out_tuser, out_tlast);
          n_fail++;
        end else begin
          e = servo_results_q.pop_front();
          if (out_tdata[4:0] !== e.ch) begin
            $display("%0t: out_channel mismatch, expected %0d, actual %0d",
                     $time, e.ch, out_tdata[4:0]);
            n_fail++;
          end
          if (out_tdata[17:5] !== e.pulse) begin
            $display("%0t: pulse mismatch on ch %0d, expected %0d, actual %0d",
                     $time, e.ch, e.pulse, $signed(out_tdata[17:5]));
            n_fail++;
          end
          if (out_tuser !== e.is_update) begin
            $display("%0t: is_update mismatch, expected %0b, actual %0b",
                     $time, e.is_update, out_tuser);
            n_fail++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, e.last, out_tlast);
            n_fail++;
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        offering = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = draw_gap(tx_calm);
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].drain_first || servo_results_q.size() == 0)) begin
          cur_cmd = cmd_q.pop_front();
          offering = 1'b1;
          in_tdata <= cur_cmd.data;
          in_tuser <= cur_cmd.op;
        end
      end
      in_tvalid <= offering;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = draw_gap(rx_calm);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long output hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (!hold_done && n_in_acc >= HOLD_AT) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n, useful, pick, ch, pw, dv, ofs, mp;
    opcode_t op;
    bit counts;

    for (int i = 0; i < NCH; i++) begin
      tgt_pw[i] = int'(REST_PULSE);
      cur_pw[i] = int'(REST_PULSE);
      step_pw[i] = 0;
      trim_pw[i] = 0;
      chan_map[i] = i;
    end

    // directed part
    queue_cmd(OP_TICK, 31, 4095, 255, -1, 31, 1'b0);   // nothing moves, marker only
    queue_cmd(OP_SET, 0, 4095, 0, 0, 0, 1'b0);         // zero divisor acts as one
    queue_cmd(OP_CAL, 1, 0, 0, -512, 0, 1'b0);
    queue_cmd(OP_SET, 1, 4095, 1, 511, 31, 1'b0);      // target above reported range
    queue_cmd(OP_CAL, 2, 4095, 255, 511, 31, 1'b0);
    queue_cmd(OP_SET, 2, 1, 255, -512, 0, 1'b0);       // negative target, slow ramp down
    queue_cmd(OP_SET, 3, 0, 5, 0, 0, 1'b0);            // zero pulse ignored
    queue_cmd(OP_SET, 6, 1500, 1, 0, 0, 1'b0);         // already there, no step
    queue_cmd(OP_SET, 31, 2000, 1, 0, 0, 1'b0);        // logical channel out of range
    queue_cmd(OP_CAL, 21, 0, 0, 100, 0, 1'b0);
    queue_cmd(OP_MAP, 25, 0, 0, 0, 3, 1'b0);
    queue_cmd(OP_MAP, 4, 0, 0, 0, 31, 1'b0);           // physical channel out of range
    queue_cmd(OP_SET, 4, 2000, 1, 0, 0, 1'b0);
    queue_cmd(OP_MAP, 5, 0, 0, 0, 20, 1'b0);
    queue_cmd(OP_MAP, 20, 0, 0, 0, 5, 1'b0);
    queue_cmd(OP_SET, 5, 100, 3, 0, 0, 1'b0);
    queue_cmd(OP_SET, 20, 3000, 200, 0, 0, 1'b0);
    for (int i = 0; i < 3; i++) queue_cmd(OP_TICK, 0, 0, 0, 0, 0, 1'b0);
    queue_cmd(OP_MAP, 4, 0, 0, 0, 4, 1'b0);
    queue_cmd(OP_MAP, 5, 0, 0, 0, 5, 1'b0);
    queue_cmd(OP_MAP, 20, 0, 0, 0, 20, 1'b0);
    queue_cmd(OP_SET, 0, 1500, 1, 0, 0, 1'b0);
    queue_cmd(OP_TICK, 0, 0, 0, 0, 0, 1'b1);

    // random part: mostly ramps and ticks, some table writes and ignored items
    n = 0;
    useful = 0;
    while (useful < RUN_ITEMS) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, NCH - 1);
      case ($urandom_range(0, 9))
        0:       pw = 0;
        1:       pw = $urandom_range(0, 4095);
        default: pw = $urandom_range(500, 2500);
      endcase
      dv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      ofs = int'($urandom_range(0, 1023)) - 512;
      mp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : ch;
      if (pick < 45) begin
        op = OP_SET;
        counts = (ch < NCH && pw > 0);
      end else if (pick < 85) begin
        op = OP_TICK;
        counts = 1'b1;
      end else if (pick < 93) begin
        op = OP_CAL;
        counts = (ch < NCH);
      end else begin
        op = OP_MAP;
        counts = (ch < NCH);
      end
      queue_cmd(op, ch, pw, dv, ofs, mp, (n == 150 || n == 300));
      n++;
      if (counts) useful++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || offering) @(posedge clk);
    while (servo_results_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/msrg_pkg.sv
rtl/core/msrg_div.sv
rtl/core/msrg_dpath.sv
rtl/core/msrg_useq.sv
rtl/core/multi_servo_ramp_generator.sv
verif/tb.sv
